/* rtl/core/ntc_pkg.sv */
// Package with the payload types, type codes and integer helpers of the type converter.
package ntc_pkg;

  typedef logic [2:0] type_code_t;
  typedef logic [1:0] cfg_index_t;

  localparam type_code_t TY_BYTE   = 3'd1;
  localparam type_code_t TY_CHAR   = 3'd2;
  localparam type_code_t TY_SHORT  = 3'd3;
  localparam type_code_t TY_INT    = 3'd4;
  localparam type_code_t TY_FLOAT  = 3'd5;
  localparam type_code_t TY_DOUBLE = 3'd6;

  localparam cfg_index_t CFG_SOURCE_TYPE = 2'd0;
  localparam cfg_index_t CFG_DEST_TYPE   = 2'd1;

  typedef struct packed {
    logic [63:0] raw_value;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [63:0] converted_value;
    logic        range_flag;
    logic        last_out;
  } out_t;

  typedef struct packed {
    logic               direct;
    logic [63:0]        dval;
    logic               dflag;
    logic               sign;
    logic [63:0]        mag;
    logic signed [12:0] expo;
    logic [5:0]         lz;
    logic               guard;
    logic               sticky;
    logic               big;
    type_code_t         dtype;
    logic               last;
  } work_t;

  function automatic logic [63:0] encode_int(input logic [63:0] u, input type_code_t t);
    logic [63:0] r;
    case (t)
      TY_BYTE:  r = {{56{u[7]}}, u[7:0]};
      TY_CHAR:  r = {56'd0, u[7:0]};
      TY_SHORT: r = {{48{u[15]}}, u[15:0]};
      default:  r = {{32{u[31]}}, u[31:0]};
    endcase
    return r;
  endfunction

  function automatic logic [63:0] sat_int(input logic neg, input type_code_t t);
    logic [63:0] r;
    case (t)
      TY_BYTE:  r = neg ? 64'hFFFF_FFFF_FFFF_FF80 : 64'd127;
      TY_CHAR:  r = neg ? 64'd0 : 64'd255;
      TY_SHORT: r = neg ? 64'hFFFF_FFFF_FFFF_8000 : 64'd32767;
      default:  r = neg ? 64'hFFFF_FFFF_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] mag_limit(input logic neg, input type_code_t t);
    logic [31:0] r;
    case (t)
      TY_BYTE:  r = neg ? 32'd128 : 32'd127;
      TY_CHAR:  r = neg ? 32'd0 : 32'd255;
      TY_SHORT: r = neg ? 32'd32768 : 32'd32767;
      default:  r = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/ntc_decode.sv */
// First stage: unpacks the source element and settles every case that needs no arithmetic.
module ntc_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_take,
  input  ntc_pkg::in_t       in_data,
  input  ntc_pkg::type_code_t src_type,
  input  ntc_pkg::type_code_t dst_type,
  output logic               valid_r,
  output ntc_pkg::work_t     work_r
);
  import ntc_pkg::*;

  work_t       work_nxt;
  logic        src_ok, dst_ok, s_int, d_int, ineg;
  logic [63:0] iv;
  logic [31:0] imag;
  logic        fs, ds;
  logic [7:0]  fe;
  logic [22:0] ff;
  logic [10:0] de;
  logic [51:0] df;

  always_comb begin
    src_ok = (src_type >= TY_BYTE) && (src_type <= TY_DOUBLE);
    dst_ok = (dst_type >= TY_BYTE) && (dst_type <= TY_DOUBLE);
    s_int  = (src_type >= TY_BYTE) && (src_type <= TY_INT);
    d_int  = (dst_type >= TY_BYTE) && (dst_type <= TY_INT);
    iv     = encode_int(in_data.raw_value, src_type);
    ineg   = (src_type != TY_CHAR) && iv[63];
    imag   = ineg ? (~iv[31:0] + 32'd1) : iv[31:0];
    fs     = in_data.raw_value[31];
    fe     = in_data.raw_value[30:23];
    ff     = in_data.raw_value[22:0];
    ds     = in_data.raw_value[63];
    de     = in_data.raw_value[62:52];
    df     = in_data.raw_value[51:0];

    work_nxt        = '0;
    work_nxt.direct = 1'b1;
    work_nxt.dtype  = dst_type;
    work_nxt.last   = in_data.last_in;

    if (!src_ok || !dst_ok) begin
      work_nxt.dval = 64'd0;
    end else if (s_int && d_int) begin
      work_nxt.dval = encode_int(iv, dst_type);
    end else if (src_type == dst_type) begin
      work_nxt.dval = (src_type == TY_FLOAT) ? {32'd0, in_data.raw_value[31:0]}
                                             : in_data.raw_value;
    end else if (s_int) begin
      if (imag != 32'd0) begin
        work_nxt.direct = 1'b0;
        work_nxt.sign   = ineg;
        work_nxt.mag    = {32'd0, imag};
        work_nxt.expo   = 13'sd0;
      end
    end else if (src_type == TY_FLOAT) begin
      if (fe == 8'hFF && ff != 23'd0) begin
        if (dst_type == TY_DOUBLE) begin
          work_nxt.dval = {fs, 11'h7FF, 1'b1, ff[21:0], 29'd0};
        end else begin
          work_nxt.dflag = 1'b1;
        end
      end else if (fe == 8'hFF) begin
        if (dst_type == TY_DOUBLE) begin
          work_nxt.dval = {fs, 11'h7FF, 52'd0};
        end else begin
          work_nxt.dval  = sat_int(fs, dst_type);
          work_nxt.dflag = 1'b1;
        end
      end else if (fe == 8'd0 && ff == 23'd0) begin
        work_nxt.dval = (dst_type == TY_DOUBLE) ? {fs, 63'd0} : 64'd0;
      end else begin
        work_nxt.direct = 1'b0;
        work_nxt.sign   = fs;
        work_nxt.mag    = {40'd0, (fe != 8'd0), ff};
        work_nxt.expo   = (fe != 8'd0) ? ($signed({5'd0, fe}) - 13'sd150) : -13'sd149;
      end
    end else begin
      if (de == 11'h7FF && df != 52'd0) begin
        if (dst_type == TY_FLOAT) begin
          work_nxt.dval = {32'd0, ds, 8'hFF, 1'b1, df[50:29]};
        end else begin
          work_nxt.dflag = 1'b1;
        end
      end else if (de == 11'h7FF) begin
        if (dst_type == TY_FLOAT) begin
          work_nxt.dval = {32'd0, ds, 8'hFF, 23'd0};
        end else begin
          work_nxt.dval  = sat_int(ds, dst_type);
          work_nxt.dflag = 1'b1;
        end
      end else if (de == 11'd0 && df == 52'd0) begin
        work_nxt.dval = (dst_type == TY_FLOAT) ? {32'd0, ds, 31'd0} : 64'd0;
      end else begin
        work_nxt.direct = 1'b0;
        work_nxt.sign   = ds;
        work_nxt.mag    = {11'd0, (de != 11'd0), df};
        work_nxt.expo   = (de != 11'd0) ? ($signed({2'd0, de}) - 13'sd1075) : -13'sd1074;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

endmodule

/* rtl/core/ntc_normalize.sv */
// Second and third stages: leading-zero count, then the normalising shift of the magnitude.
module ntc_normalize (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_in,
  input  ntc_pkg::work_t work_in,
  output logic           valid_r,
  output ntc_pkg::work_t work_r
);
  import ntc_pkg::*;

  function automatic logic [5:0] lzc64(input logic [63:0] m);
    logic [6:0] n;
    logic       found;
    n     = 7'd0;
    found = 1'b0;
    for (int i = 63; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) begin
          found = 1'b1;
        end else begin
          n = n + 7'd1;
        end
      end
    end
    return n[5:0];
  endfunction

  work_t cnt_nxt, cnt_r, work_nxt;
  logic  cnt_valid_r;

  always_comb begin
    cnt_nxt    = work_in;
    cnt_nxt.lz = lzc64(work_in.mag);
  end

  always_comb begin
    work_nxt      = cnt_r;
    work_nxt.mag  = cnt_r.mag << cnt_r.lz;
    work_nxt.expo = cnt_r.expo + 13'sd63 - $signed({7'd0, cnt_r.lz});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_valid_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      cnt_valid_r <= valid_in;
      valid_r     <= cnt_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    work_r <= work_nxt;
  end

endmodule

/* rtl/core/ntc_round.sv */
// Fourth and fifth stages: alignment to the destination precision, then rounding and packing.
module ntc_round (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           valid_in,
  input  ntc_pkg::work_t work_in,
  output logic           valid_r,
  output ntc_pkg::out_t  out_r
);
  import ntc_pkg::*;

  work_t              align_nxt, align_r;
  logic               align_valid_r;
  out_t               out_nxt;
  logic               is_fp;
  logic signed [12:0] be, base, rs;
  logic [11:0]        ebase;
  logic [6:0]         r;
  logic [129:0]       ext;
  logic               inc;
  logic [34:0]        sum_s;
  logic [63:0]        sum_d;
  logic [63:0]        sval;

  always_comb begin
    is_fp = (work_in.dtype == TY_FLOAT) || (work_in.dtype == TY_DOUBLE);
    be    = (work_in.dtype == TY_FLOAT) ? (work_in.expo + 13'sd127)
                                        : (work_in.expo + 13'sd1023);
    base  = (work_in.dtype == TY_FLOAT) ? 13'sd40 : 13'sd11;
    ebase = 12'd0;
    align_nxt     = work_in;
    align_nxt.big = 1'b0;
    if (is_fp) begin
      if (be >= 13'sd1) begin
        rs    = base;
        ebase = be[11:0];
      end else begin
        rs = base + 13'sd1 - be;
      end
    end else if (work_in.expo < 13'sd0) begin
      rs = 13'sd66;
    end else if (work_in.expo > 13'sd40) begin
      rs            = 13'sd0;
      align_nxt.big = 1'b1;
    end else begin
      rs = 13'sd63 - work_in.expo;
    end
    r   = (rs > 13'sd66) ? 7'd66 : rs[6:0];
    ext = {work_in.mag, 66'd0} >> r;
    align_nxt.mag    = ext[129:66];
    align_nxt.guard  = ext[65];
    align_nxt.sticky = |ext[64:0];
    align_nxt.expo   = $signed({1'b0, ebase});
  end

  always_comb begin
    inc   = align_r.guard & (align_r.sticky | align_r.mag[0]);
    sum_s = {align_r.expo[11:0], align_r.mag[22:0]} + {34'd0, inc};
    sum_d = {align_r.expo[11:0], align_r.mag[51:0]} + {63'd0, inc};
    sval  = align_r.sign ? (~align_r.mag + 64'd1) : align_r.mag;
    out_nxt.last_out   = align_r.last;
    out_nxt.range_flag = 1'b0;
    if (align_r.direct) begin
      out_nxt.converted_value = align_r.dval;
      out_nxt.range_flag      = align_r.dflag;
    end else if (align_r.dtype == TY_FLOAT) begin
      out_nxt.converted_value = (sum_s[34:23] >= 12'd255)
                              ? {32'd0, align_r.sign, 8'hFF, 23'd0}
                              : {32'd0, align_r.sign, sum_s[30:0]};
    end else if (align_r.dtype == TY_DOUBLE) begin
      out_nxt.converted_value = (sum_d[63:52] >= 12'd2047)
                              ? {align_r.sign, 11'h7FF, 52'd0}
                              : {align_r.sign, sum_d[62:0]};
    end else if (align_r.big ||
                 align_r.mag > {32'd0, mag_limit(align_r.sign, align_r.dtype)}) begin
      out_nxt.converted_value = sat_int(align_r.sign, align_r.dtype);
      out_nxt.range_flag      = 1'b1;
    end else begin
      out_nxt.converted_value = encode_int(sval, align_r.dtype);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_valid_r <= 1'b0;
      valid_r       <= 1'b0;
    end else begin
      align_valid_r <= valid_in;
      valid_r       <= align_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    align_r <= align_nxt;
    out_r   <= out_nxt;
  end

endmodule

/* rtl/core/numeric_type_converter.sv */
// Top level of the numeric element type converter: configuration registers and pipeline.
//
//   Channel   Ports                              Beat taken when
//   input     start, busy, in_data               start high and busy low
//   result    out_valid, out_data                out_valid high, one cycle
//   config    cfg_we, cfg_index, cfg_wdata       cfg_we high
//
// A beat is accepted in every cycle in which start is high; busy is always low.
// Each result passes through one register stage each for decode, leading-zero count,
// normalising shift, alignment and rounding, the first of them loaded at the
// accepting edge.
// Reset clears the stage valid bits and sets both type registers to double.
// The receiver cannot hold results off, so the pipeline never stalls.
module numeric_type_converter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ntc_pkg::in_t        in_data,
  output logic                out_valid,
  output ntc_pkg::out_t       out_data,
  input  logic                cfg_we,
  input  ntc_pkg::cfg_index_t cfg_index,
  input  logic [2:0]          cfg_wdata
);
  import ntc_pkg::*;

  type_code_t src_type_r, dst_type_r;
  logic       dec_valid, norm_valid;
  work_t      dec_work, norm_work;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_type_r <= TY_DOUBLE;
      dst_type_r <= TY_DOUBLE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SOURCE_TYPE: src_type_r <= cfg_wdata;
        CFG_DEST_TYPE:   dst_type_r <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  ntc_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_take  (start & ~busy),
    .in_data  (in_data),
    .src_type (src_type_r),
    .dst_type (dst_type_r),
    .valid_r  (dec_valid),
    .work_r   (dec_work)
  );

  ntc_normalize u_normalize (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (dec_valid),
    .work_in  (dec_work),
    .valid_r  (norm_valid),
    .work_r   (norm_work)
  );

  ntc_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (norm_valid),
    .work_in  (norm_work),
    .valid_r  (out_valid),
    .out_r    (out_data)
  );

endmodule
